// ===== hw/rtl/ordered_dither_bitpack_unit_assert.svh =====
// assertion macros shared by the dither bit packer modules
// both expect clk and arst_n in the enclosing module
`ifndef ORDERED_DITHER_BITPACK_UNIT_ASSERT_SVH
`define ORDERED_DITHER_BITPACK_UNIT_ASSERT_SVH

// same-cycle implication
`define ODBP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odbp assertion failed");

// next-cycle implication
`define ODBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odbp assertion failed");

`endif

// ===== hw/rtl/odbp_pkg.sv =====
`timescale 1ns / 1ps

package odbp_pkg;

	// grid and field sizes
	localparam int RowPoints  = 256;
	localparam int MatrixSize = 16;
	localparam int ColW       = $clog2(RowPoints);
	localparam int MatIdxW    = $clog2(MatrixSize);
	localparam int SampleW    = 8;
	localparam int RowW       = 8;
	localparam int OctetW     = 8;
	localparam int BitPosW    = $clog2(OctetW);

	typedef logic [OctetW-1:0] octet_t;

	// everything one item produces, handed to the output stage
	typedef struct packed {
		logic            hdr;
		logic            data_vld;
		logic [RowW-1:0] row_num;
		octet_t          data_byte;
		logic            row_last;
	} bundle_t;

	// 16x16 bayer threshold: bit-reversed interleave of (col ^ row) and row
	function automatic octet_t bayer_thresh(input logic [MatIdxW-1:0] mrow,
			input logic [MatIdxW-1:0] mcol);
		logic [MatIdxW-1:0] x;
		begin
			x = mrow ^ mcol;
			bayer_thresh = {x[0], mrow[0], x[1], mrow[1], x[2], mrow[2], x[3], mrow[3]};
		end
	endfunction

endpackage

// ===== hw/rtl/odbp_pix_if.sv =====
`timescale 1ns / 1ps

interface odbp_pix_if;
	logic                         valid;
	logic                         ready;
	logic [odbp_pkg::SampleW-1:0] gray_sample;
	logic                         inside_image;

	modport source (output valid, output gray_sample, output inside_image, input ready);
	modport sink   (input valid, input gray_sample, input inside_image, output ready);
endinterface

// ===== hw/rtl/odbp_byte_if.sv =====
`timescale 1ns / 1ps

interface odbp_byte_if;
	logic             valid;
	logic             ready;
	odbp_pkg::octet_t out_byte;
	logic             is_header;
	logic             row_last;

	modport source (output valid, output out_byte, output is_header, output row_last, input ready);
	modport sink   (input valid, input out_byte, input is_header, input row_last, output ready);
endinterface

// ===== hw/rtl/odbp_dither.sv =====
`timescale 1ns / 1ps

`include "ordered_dither_bitpack_unit_assert.svh"

module odbp_dither (
	input  logic              clk,
	input  logic              arst_n,
	odbp_pix_if.sink          pix_in,
	output odbp_pkg::bundle_t bnd,
	output logic              bnd_vld,
	input  logic              bnd_ready
);

	logic                            vld_s1;
	logic [odbp_pkg::SampleW-1:0]    sample_s1;
	logic                            inside_s1;

	logic [odbp_pkg::ColW-1:0]       col_q;
	logic [odbp_pkg::RowW-1:0]       row_q;
	odbp_pkg::octet_t                acc_q;
	logic [odbp_pkg::BitPosW-1:0]    pos_q;

	logic                            at_row_end;
	logic                            hdr;
	logic                            byte_done;
	logic                            hit;
	odbp_pkg::octet_t                thresh;
	odbp_pkg::octet_t                acc_new;
	logic                            has_res;
	logic                            adv;

	// threshold compare and bit insertion
	always_comb begin
		at_row_end = (col_q == odbp_pkg::ColW'(odbp_pkg::RowPoints - 1));
		hdr        = (col_q == '0);
		byte_done  = &pos_q;
		thresh     = odbp_pkg::bayer_thresh(row_q[odbp_pkg::MatIdxW-1:0],
				col_q[odbp_pkg::MatIdxW-1:0]);
		hit        = inside_s1 && (sample_s1 <= thresh);
		acc_new    = acc_q | (hit ? (odbp_pkg::octet_t'(8'h80) >> pos_q) : '0);
		has_res    = hdr || byte_done;
	end

	// hand results to the output stage; items without results just advance
	assign adv          = vld_s1 && (!has_res || bnd_ready);
	assign bnd_vld      = vld_s1 && has_res;
	assign pix_in.ready = !vld_s1 || adv;

	always_comb begin
		bnd.hdr       = hdr;
		bnd.data_vld  = byte_done;
		bnd.row_num   = row_q;
		bnd.data_byte = acc_new;
		bnd.row_last  = at_row_end;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			vld_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.ready && pix_in.valid) begin
			sample_s1 <= pix_in.gray_sample;
			inside_s1 <= pix_in.inside_image;
		end
	end

	// row, column and packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			acc_q <= '0;
			pos_q <= '0;
		end else if (adv) begin
			pos_q <= pos_q + 1'b1;
			acc_q <= byte_done ? '0 : acc_new;
			if (at_row_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	`ODBP_ASSERT_NEXT(a_row_wrap, adv && at_row_end, (col_q == '0) && (row_q == $past(row_q) + 1'b1))
	`ODBP_ASSERT_NEXT(a_acc_clear, adv && byte_done, acc_q == '0)
	`ODBP_ASSERT_NEXT(a_s1_hold, vld_s1 && !adv, vld_s1 && $stable(sample_s1) && $stable(col_q))

endmodule

// ===== hw/rtl/odbp_out.sv =====
`timescale 1ns / 1ps

`include "ordered_dither_bitpack_unit_assert.svh"

module odbp_out (
	input  logic              clk,
	input  logic              arst_n,
	input  odbp_pkg::bundle_t bnd,
	input  logic              bnd_vld,
	output logic              bnd_ready,
	odbp_byte_if.source       byte_out
);

	logic                      pend_hi_q;
	logic                      pend_lo_q;
	logic                      pend_dat_q;
	logic [odbp_pkg::RowW-1:0] row_q;
	odbp_pkg::octet_t          dat_q;
	logic                      last_q;

	logic                      any;
	logic                      more;
	logic                      single;
	logic                      take;
	logic                      ld;

	// pending result bookkeeping
	always_comb begin
		any    = pend_hi_q || pend_lo_q || pend_dat_q;
		more   = (pend_hi_q && (pend_lo_q || pend_dat_q)) || (pend_lo_q && pend_dat_q);
		single = any && !more;
		take   = byte_out.valid && byte_out.ready;
	end

	assign bnd_ready = !any || (take && single);
	assign ld        = bnd_vld && bnd_ready;

	// present the oldest pending result: high header, low header, data
	always_comb begin
		byte_out.valid = any;
		if (pend_hi_q) begin
			byte_out.out_byte  = '0;
			byte_out.is_header = 1'b1;
			byte_out.row_last  = 1'b0;
		end else if (pend_lo_q) begin
			byte_out.out_byte  = odbp_pkg::octet_t'(row_q);
			byte_out.is_header = 1'b1;
			byte_out.row_last  = 1'b0;
		end else begin
			byte_out.out_byte  = dat_q;
			byte_out.is_header = 1'b0;
			byte_out.row_last  = last_q;
		end
	end

	// pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_hi_q  <= 1'b0;
			pend_lo_q  <= 1'b0;
			pend_dat_q <= 1'b0;
		end else if (ld) begin
			pend_hi_q  <= bnd.hdr;
			pend_lo_q  <= bnd.hdr;
			pend_dat_q <= bnd.data_vld;
		end else if (take) begin
			if (pend_hi_q) begin
				pend_hi_q <= 1'b0;
			end else if (pend_lo_q) begin
				pend_lo_q <= 1'b0;
			end else begin
				pend_dat_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ld) begin
			row_q  <= bnd.row_num;
			dat_q  <= bnd.data_byte;
			last_q <= bnd.row_last;
		end
	end

	`ODBP_ASSERT_SAME(a_hdr_pair, pend_hi_q, pend_lo_q)
	`ODBP_ASSERT_NEXT(a_drain, take && single && !ld, !byte_out.valid)
	`ODBP_ASSERT_SAME(a_hdr_not_last, byte_out.valid && byte_out.is_header, !byte_out.row_last)

endmodule

// ===== hw/rtl/ordered_dither_bitpack_unit.sv =====
`timescale 1ns / 1ps

// Ordered dither bit packer: takes one 8-bit gray sample per clock on a grid of
// 256 points per row, thresholds it against a 16x16 bayer matrix (indexed by the
// low bits of row and column) and packs the bits MSB first into bytes, with two
// row-number header bytes ahead of each row's data. Sustained rate is one item
// per clock while the output keeps its ready high; an accepted sample is held in
// the input register, then its result in the pending registers of the output
// stage. The output port delivers at most one byte per clock. The two header
// bytes at the start of a row drain while the following points, which yield no
// byte, keep flowing; the input only waits while the output holds back its ready.
module ordered_dither_bitpack_unit (
	input  logic        clk,
	input  logic        arst_n,
	odbp_pix_if.sink    pix_in,
	odbp_byte_if.source byte_out
);

	odbp_pkg::bundle_t bnd;
	logic              bnd_vld;
	logic              bnd_ready;

	// threshold and packing stage
	odbp_dither u_dither (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.bnd       (bnd),
		.bnd_vld   (bnd_vld),
		.bnd_ready (bnd_ready)
	);

	// result register and serializer
	odbp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd       (bnd),
		.bnd_vld   (bnd_vld),
		.bnd_ready (bnd_ready),
		.byte_out  (byte_out)
	);

endmodule
